// ===== src/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg: shared constants and types for the Sobel edge magnitude block
// Frame limits, register indexes, field widths and the pixel type.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int AW_W       = COL_W + 1;
    localparam int ROW_W      = 13;
    localparam int AH_W       = 13;
    localparam int PEND_W     = 11;
    localparam int SQ_W       = 21;
    localparam int GRAD_W     = 11;
    localparam int MAG_W      = 8;
    localparam int CFG_DATA_W = 13;

    localparam logic [MAG_W-1:0] MAG_CAP = 8'd255;

    localparam logic [AW_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [AH_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef logic [23:0] t_pix;

endpackage

// ===== src/sobel_edge_magnitude_top.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_top: streaming 3x3 Sobel edge magnitude on RGB pixels
// Line memory plus 3x3 window, gradient, square and rounded root per channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction per item:
//   i_cmd low is a pixel in raster order, i_cmd high is a flush after the
//   frame end. Send frame_width + 1 flushes after the last pixel to drain.
//   Output channel (o_out_valid / i_out_stall) carries one magnitude per
//   channel, clamped to 255; o_frame_last marks the frame's final pixel.
//   A result belongs to the position one row plus one pixel before the
//   item that produced it, so the first row gives no results.
//   The block takes one item at a time. An item without result goes through
//   memory read, then write back; an item with a result goes through push,
//   gradient, square, the 11-step root iteration (started by a strobe
//   registered together with the square) and the output load.
//   The next item is taken while a finished result waits in the output
//   register; a stalled receiver holds the block only when a second result
//   is ready to load.
//   Config writes (i_cfg_we) take effect at the next frame start.
//   Reset (synchronous, active low) clears positions, window and owed
//   flushes, and sets the frame to 640 x 480. The line memory needs no
//   clearing: unwritten entries only feed neighbors outside the frame.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_addr,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_cmd,
    input  logic [7:0]                      i_in_red,
    input  logic [7:0]                      i_in_green,
    input  logic [7:0]                      i_in_blue,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out_red,
    output logic [7:0]                      o_out_green,
    output logic [7:0]                      o_out_blue,
    output logic                            o_frame_last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PUSH = 3'd1;
    localparam logic [2:0] S_GRAD = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_ROOT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam int CW = sem_pkg::COL_W;
    localparam int AW = sem_pkg::AW_W;
    localparam int RW = sem_pkg::ROW_W;
    localparam int HW = sem_pkg::AH_W;
    localparam int PW = sem_pkg::PEND_W;
    localparam int GW = sem_pkg::GRAD_W;
    localparam int QW = sem_pkg::SQ_W;

    // configuration and frame geometry in effect
    logic [AW-1:0]  r_cfg_w;
    logic [HW-1:0]  r_cfg_h;
    logic [AW-1:0]  r_aw;
    logic [HW-1:0]  r_ah;

    // stream position and drain bookkeeping
    logic [2:0]     r_state;
    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [PW-1:0]  r_pending;
    logic           r_flush;
    sem_pkg::t_pix  r_pix;
    sem_pkg::t_pix  r_win [3][3];

    // per-result pipeline
    logic [2:0]          r_rmask;
    logic [2:0]          r_cmask;
    logic                r_last;
    logic signed [GW-1:0] r_gx [3];
    logic signed [GW-1:0] r_gy [3];
    logic [QW-1:0]       r_sq [3];
    logic                r_root_start;

    // rounded roots, one unit per channel
    logic       root_done_c [3];
    logic       root_done;
    logic [7:0] root_mag [3];

    // output register
    logic           r_out_valid;
    logic [7:0]     r_out_mag [3];
    logic           r_out_last;

    // ---------------- accept decode ----------------
    logic           acc;
    logic           drop_pend;
    logic           go_push;
    logic           is_start;
    logic [CW-1:0]  start_col;
    logic [RW-1:0]  start_row;
    logic [AW-1:0]  w_clamp;
    logic [HW-1:0]  h_clamp;

    assign acc       = i_in_valid && !o_in_stall;
    assign drop_pend = !i_cmd && (r_pending != '0);
    assign start_col = drop_pend ? '0 : r_col;
    assign start_row = drop_pend ? '0 : r_row;
    assign is_start  = !i_cmd && (start_col == '0) && (start_row == '0);
    assign go_push   = acc && (!i_cmd || (r_pending != '0));

    // zero acts as one, above the maximum acts as the maximum
    always_comb begin
        if (r_cfg_w == '0) begin
            w_clamp = AW'(1);
        end else if (r_cfg_w > AW'(sem_pkg::MAX_WIDTH)) begin
            w_clamp = AW'(sem_pkg::MAX_WIDTH);
        end else begin
            w_clamp = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            h_clamp = HW'(1);
        end else if (r_cfg_h > HW'(sem_pkg::MAX_HEIGHT)) begin
            h_clamp = HW'(sem_pkg::MAX_HEIGHT);
        end else begin
            h_clamp = r_cfg_h;
        end
    end

    // ---------------- line memory: {upper, middle} per column ----------------
    logic [47:0]    ram_rdata;
    sem_pkg::t_pix  top_pix;
    sem_pkg::t_pix  mid_pix;
    logic           ram_we;

    assign ram_we  = (r_state == S_PUSH);
    assign top_pix = ram_rdata[47:24];
    assign mid_pix = ram_rdata[23:0];

    sem_ram #(
        .WIDTH (48),
        .DEPTH (sem_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col),
        .i_wdata ({mid_pix, r_pix}),
        .i_re    (go_push),
        .i_raddr (start_col),
        .o_rdata (ram_rdata)
    );

    // ---------------- push: position update and output geometry ----------------
    logic [AW-1:0]        col_inc;
    logic                 wrap;
    logic [CW-1:0]        next_col;
    logic [RW-1:0]        next_row;
    logic signed [RW:0]   orow;
    logic [CW-1:0]        ocol;
    logic                 out_ok;
    logic [PW-1:0]        pend_dec;

    assign col_inc  = {1'b0, r_col} + AW'(1);
    assign wrap     = (col_inc >= r_aw);
    assign next_col = wrap ? '0 : col_inc[CW-1:0];
    assign next_row = r_row + RW'(wrap);
    assign orow     = (r_col != '0) ? ($signed({1'b0, r_row}) - (RW+1)'(1))
                                    : ($signed({1'b0, r_row}) - (RW+1)'(2));
    assign ocol     = (r_col != '0) ? (r_col - CW'(1)) : CW'(r_aw - AW'(1));
    assign out_ok   = (orow >= 0) && (orow < $signed({1'b0, r_ah}));
    assign pend_dec = r_pending - PW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_col        <= '0;
            r_row        <= '0;
            r_pending    <= '0;
            r_cfg_w      <= sem_pkg::WIDTH_RESET;
            r_cfg_h      <= sem_pkg::HEIGHT_RESET;
            r_aw         <= sem_pkg::WIDTH_RESET;
            r_ah         <= sem_pkg::HEIGHT_RESET;
            r_root_start <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            r_root_start <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_addr == sem_pkg::CFG_FRAME_WIDTH) begin
                    r_cfg_w <= i_cfg_wdata[AW-1:0];
                end else begin
                    r_cfg_h <= i_cfg_wdata;
                end
            end
            // drain the output register on a completed transaction,
            // unless the output step reloads it in the same cycle
            if (o_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    // a pixel abandons any drain; a flush with nothing owed is dropped
                    if (go_push) begin
                        r_col   <= start_col;
                        r_row   <= start_row;
                        r_flush <= i_cmd;
                        r_pix   <= i_cmd ? '0 : {i_in_red, i_in_green, i_in_blue};
                        if (drop_pend) begin
                            r_pending <= '0;
                        end
                        if (is_start) begin
                            r_aw <= w_clamp;
                            r_ah <= h_clamp;
                        end
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    // shift the window and load the new column
                    for (int i = 0; i < 3; i++) begin
                        r_win[i][0] <= r_win[i][1];
                        r_win[i][1] <= r_win[i][2];
                    end
                    r_win[0][2] <= top_pix;
                    r_win[1][2] <= mid_pix;
                    r_win[2][2] <= r_pix;
                    r_rmask <= {(orow + (RW+1)'(1)) < $signed({1'b0, r_ah}), 1'b1,
                                orow != '0};
                    r_cmask <= {({1'b0, ocol} + AW'(1)) < r_aw, 1'b1, ocol != '0};
                    r_last  <= (orow == $signed({1'b0, r_ah} - (HW+1)'(1)))
                               && ({1'b0, ocol} == r_aw - AW'(1));
                    if (r_flush) begin
                        r_pending <= pend_dec;
                        if (pend_dec == '0) begin
                            r_col <= '0;
                            r_row <= '0;
                        end else begin
                            r_col <= next_col;
                            r_row <= next_row;
                        end
                    end else begin
                        r_col <= next_col;
                        r_row <= next_row;
                        // frame complete: owe one row plus one pixel of flushes
                        if (next_row >= r_ah) begin
                            r_pending <= PW'(r_aw + AW'(1));
                        end
                    end
                    r_state <= out_ok ? S_GRAD : S_IDLE;
                end
                S_GRAD: begin
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_root_start <= 1'b1;
                    r_state      <= S_ROOT;
                end
                S_ROOT: begin
                    if (!r_root_start && root_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------- gradients ----------------
    logic signed [GW-1:0] a [3][3];
    logic signed [GW-1:0] gx_c [3];
    logic signed [GW-1:0] gy_c [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    a[i][j] = (r_rmask[i] && r_cmask[j])
                              ? $signed({3'b000, r_win[i][j][16-8*ch +: 8]}) : '0;
                end
            end
            gx_c[ch] = (a[0][2] - a[0][0]) + ((a[1][2] - a[1][0]) <<< 1)
                       + (a[2][2] - a[2][0]);
            gy_c[ch] = (a[2][0] - a[0][0]) + ((a[2][1] - a[0][1]) <<< 1)
                       + (a[2][2] - a[0][2]);
        end
    end

    logic signed [2*GW-1:0] sq_full [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sq_full[ch] = r_gx[ch] * r_gx[ch] + r_gy[ch] * r_gy[ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_GRAD) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_gx[ch] <= gx_c[ch];
                r_gy[ch] <= gy_c[ch];
            end
        end
        if (r_state == S_SQ) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_sq[ch] <= sq_full[ch][QW-1:0];
            end
        end
        if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_out_mag[ch] <= root_mag[ch];
            end
            r_out_last <= r_last;
        end
    end

    // ---------------- rounded roots, one unit per channel ----------------
    for (genvar ch = 0; ch < 3; ch++) begin : g_root
        sem_root u_root (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_root_start),
            .i_sq    (r_sq[ch]),
            .o_done  (root_done_c[ch]),
            .o_mag   (root_mag[ch])
        );
    end

    assign root_done = root_done_c[0] && root_done_c[1] && root_done_c[2];

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_red    = r_out_mag[0];
    assign o_out_green  = r_out_mag[1];
    assign o_out_blue   = r_out_mag[2];
    assign o_frame_last = r_out_last;

    // ---------------- assertions ----------------
    a_drain_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != '0) |-> (r_row >= r_ah))
        else $error("flushes owed before the frame was complete");

    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ({1'b0, r_col} < r_aw))
        else $error("column position outside the active width");

    a_push_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |=> (r_state == S_GRAD || r_state == S_IDLE))
        else $error("push step not followed by gradient or idle");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result loaded outside the output step");

endmodule

// ===== src/sem_ram.sv =====
// ----------------------------------------------------------------------------
// sem_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sem_root.sv =====
// ----------------------------------------------------------------------------
// sem_root: rounded integer square root, one result bit per cycle
// Digit-by-digit root, then round to nearest and clamp.
// ----------------------------------------------------------------------------
module sem_root (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sem_pkg::SQ_W-1:0]     i_sq,
    output logic                         o_done,
    output logic [sem_pkg::MAG_W-1:0]    o_mag
);

    logic [sem_pkg::SQ_W-1:0] r_rem;
    logic [sem_pkg::SQ_W-1:0] r_res;
    logic [sem_pkg::SQ_W-1:0] r_bit;
    logic                     r_busy;
    logic                     r_done;
    logic [sem_pkg::SQ_W:0]   trial;
    logic [sem_pkg::SQ_W:0]   rounded;

    assign trial = {1'b0, r_res} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_bit[0]) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_sq;
            r_res <= '0;
            r_bit <= {1'b1, {(sem_pkg::SQ_W-1){1'b0}}};
        end else if (r_busy) begin
            // accept the trial digit when the remainder covers it
            if ({1'b0, r_rem} >= trial) begin
                r_rem <= r_rem - trial[sem_pkg::SQ_W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // remainder above the root means the true root lies past the half point
    assign rounded = {1'b0, r_res} + {{sem_pkg::SQ_W{1'b0}}, (r_rem > r_res)};
    assign o_mag   = (rounded > {{(sem_pkg::SQ_W+1-sem_pkg::MAG_W){1'b0}}, sem_pkg::MAG_CAP})
                     ? sem_pkg::MAG_CAP : rounded[sem_pkg::MAG_W-1:0];
    assign o_done  = r_done;

endmodule

// ===== tb/tb_sobel_edge_magnitude_top.sv =====
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude_top: self-checking bench for the Sobel edge block
// Streams RGB frames of many sizes through the block, predicts every
// magnitude with an independent line-store and window model, and compares
// each result transaction field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;
    localparam int   SETTLE_CYCLES = 60;   // margin for a result still in flight
    localparam int   RANDOM_ITEMS  = 560;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_mag;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic                           i_cfg_addr;
    logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_wdata;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic                           i_cmd;
    logic [7:0]                     i_in_red;
    logic [7:0]                     i_in_green;
    logic [7:0]                     i_in_blue;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [7:0]                     o_out_red;
    logic [7:0]                     o_out_green;
    logic [7:0]                     o_out_blue;
    logic                           o_frame_last;

    sobel_edge_magnitude_top i_dut (.*);

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stream predictor: own copy of the line stores, window and positions
    // ------------------------------------------------------------------------
    sem_pkg::t_pix row_above [sem_pkg::MAX_WIDTH];
    sem_pkg::t_pix row_prev  [sem_pkg::MAX_WIDTH];
    sem_pkg::t_pix win [3][3];
    int unsigned col_pos, row_pos, owed_flushes;
    int unsigned reg_width, reg_height;   // register contents as written
    int unsigned cur_width, cur_height;   // frame size latched at frame start

    t_mag        expected_mags[$];
    int          mismatches;
    int          results_seen;
    int          items_sent;
    int          frames_sent;

    // nearest integer to the square root, capped at 255
    function automatic logic [7:0] rounded_sqrt(int unsigned s);
        int unsigned r;
        int unsigned t;
        r = 0;
        for (int b = 11; b >= 0; b--) begin
            t = r | (1 << b);
            if (t * t <= s) r = t;
        end
        if (s > r * r + r) r++;
        return (r > 255) ? sem_pkg::MAG_CAP : r[7:0];
    endfunction

    function automatic int unsigned fit_width(int unsigned w);
        if (w == 0) return 1;
        if (w > sem_pkg::MAX_WIDTH) return sem_pkg::MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned fit_height(int unsigned h);
        if (h == 0) return 1;
        if (h > sem_pkg::MAX_HEIGHT) return sem_pkg::MAX_HEIGHT;
        return h;
    endfunction

    // shift one pixel into the window; report the magnitude one row and one
    // pixel back, if that position lies inside the frame
    task automatic shift_pixel(input sem_pkg::t_pix pix, output bit got, output t_mag mag);
        int unsigned   c;
        int            orow, ocol, rr, cc, gx, gy, v, w, h;
        sem_pkg::t_pix top, mid;
        logic [7:0]    chan [3];
        c = col_pos;
        w = cur_width;
        h = cur_height;
        got = 1'b0;
        mag = '0;
        if (c >= sem_pkg::MAX_WIDTH || c >= cur_width) c = 0;
        top = row_above[c];
        mid = row_prev[c];
        row_above[c] = mid;
        row_prev[c]  = pix;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = pix;
        if (c >= 1) begin
            orow = int'(row_pos) - 1;
            ocol = int'(c) - 1;
        end else begin
            orow = int'(row_pos) - 2;
            ocol = w - 1;
        end
        c++;
        if (c >= cur_width) begin
            c = 0;
            row_pos++;
        end
        col_pos = c;
        if (orow < 0 || orow >= h) return;
        for (int ch = 0; ch < 3; ch++) begin
            gx = 0;
            gy = 0;
            for (int i = 0; i < 3; i++) begin
                rr = orow + i - 1;
                for (int j = 0; j < 3; j++) begin
                    cc = ocol + j - 1;
                    if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
                        v = int'(win[i][j][16 - 8 * ch +: 8]);
                        // Gx weights columns -1/0/+1, doubled on the middle row
                        gx += (j - 1) * ((i == 1) ? 2 : 1) * v;
                        gy += (i - 1) * ((j == 1) ? 2 : 1) * v;
                    end
                end
            end
            chan[ch] = rounded_sqrt(gx * gx + gy * gy);
        end
        got = 1'b1;
        mag.red   = chan[0];
        mag.green = chan[1];
        mag.blue  = chan[2];
        mag.last  = (orow == h - 1 && ocol == w - 1);
    endtask

    // advance the predicted stream by one accepted transaction
    task automatic predict_item(input logic cmd, input sem_pkg::t_pix pix);
        bit   got;
        t_mag mag;
        got = 1'b0;
        if (cmd == CMD_PIXEL) begin
            // a pixel during a drain abandons it and opens a new frame
            if (owed_flushes != 0) begin
                owed_flushes = 0;
                col_pos = 0;
                row_pos = 0;
            end
            if (col_pos == 0 && row_pos == 0) begin
                cur_width  = fit_width(reg_width);
                cur_height = fit_height(reg_height);
            end
            shift_pixel(pix, got, mag);
            if (row_pos >= cur_height) owed_flushes = cur_width + 1;
        end else if (owed_flushes != 0) begin
            // flush payload is ignored; zero enters the window
            shift_pixel('0, got, mag);
            owed_flushes--;
            if (owed_flushes == 0) begin
                col_pos = 0;
                row_pos = 0;
            end
        end
        if (got) expected_mags.push_back(mag);
    endtask

    // ------------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps
    // ------------------------------------------------------------------------
    int burst_left;

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic cmd, input logic [7:0] r, g, b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_in_red   <= r;
        i_in_green <= g;
        i_in_blue  <= b;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(cmd, {r, g, b});
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_pixel_rand();
        logic [7:0] r, g, b;
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        // bias toward the channel extremes now and then
        case ($urandom_range(0, 7))
            0: r = 8'hFF;
            1: g = 8'h00;
            2: b = 8'hFF;
            default: ;
        endcase
        send_item(CMD_PIXEL, r, g, b);
    endtask

    task automatic send_flushes(input int n);
        repeat (n) send_item(CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // drop valid, wait for every owed result, then let the pipeline empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_mags.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // write both registers while the block is idle; call at a falling edge
    task automatic set_frame(input int unsigned w, input int unsigned h);
        i_in_valid  <= 1'b0;
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= sem_pkg::CFG_FRAME_WIDTH;
        i_cfg_wdata <= sem_pkg::CFG_DATA_W'(w);
        @(negedge i_clk);
        i_cfg_addr  <= sem_pkg::CFG_FRAME_HEIGHT;
        i_cfg_wdata <= sem_pkg::CFG_DATA_W'(h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        reg_width  = w & 32'h7FF;
        reg_height = h & 32'h1FFF;
    endtask

    task automatic send_frame_rand(input int unsigned w, input int unsigned h);
        repeat (fit_width(w) * fit_height(h)) send_pixel_rand();
        send_flushes(fit_width(w) + 1);
        frames_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall pattern that changes mode every so often
    // ------------------------------------------------------------------------
    initial begin
        int mode;
        int left;
        i_out_stall = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 300);
            end
            left--;
            case (mode)
                0: i_out_stall <= 1'b0;                            // free running
                1: i_out_stall <= ($urandom_range(0, 3) == 0);     // light stalls
                2: i_out_stall <= ($urandom_range(0, 1) == 0);     // heavy stalls
                default: i_out_stall <= ((left % 23) < 15);        // long stall runs
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each result transaction with the oldest one owed
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_mag want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_mags.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %0d/%0d/%0d last=%0b",
                             o_out_red, o_out_green, o_out_blue, o_frame_last);
            end else begin
                want = expected_mags.pop_front();
                if (o_out_red !== want.red || o_out_green !== want.green ||
                    o_out_blue !== want.blue || o_frame_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d expected %0d/%0d/%0d last=%0b",
                                 results_seen, want.red, want.green, want.blue,
                                 want.last, ", got %0d/%0d/%0d last=%0b",
                                 o_out_red, o_out_green, o_out_blue, o_frame_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // small frame of channel extremes at the reset-free sizes
    task automatic test_extremes();
        set_frame(3, 3);
        // checkerboard of full and empty pixels drives magnitudes past the cap
        for (int p = 0; p < 9; p++) begin
            if (p % 2 == 0) send_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
            else            send_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
        end
        send_flushes(4);
        settle();
    endtask

    // flush with nothing owed, early flush of a single-row frame, drain abandon
    task automatic test_special_cases();
        send_flushes(2);                  // nothing owed: ignored
        set_frame(3, 1);
        repeat (3) send_pixel_rand();
        send_flushes(4);                  // first flush gives no result
        settle();
        set_frame(2, 2);
        repeat (4) send_pixel_rand();
        send_flushes(1);                  // abandon the drain with a pixel
        settle();
        repeat (4) send_pixel_rand();
        send_flushes(3);
        settle();
    endtask

    // register write between pixels of one frame applies to the next frame
    task automatic test_mid_frame_config();
        set_frame(4, 3);
        repeat (5) send_pixel_rand();
        settle();
        set_frame(2, 2);
        repeat (7) send_pixel_rand();
        send_flushes(5);
        settle();
        send_frame_rand(2, 2);
        settle();
    endtask

    // width past its limit with a short drain, then zero width and height
    task automatic test_size_limits();
        set_frame(2047, 1);               // acts as the widest frame
        repeat (sem_pkg::MAX_WIDTH) send_pixel_rand();
        send_flushes(3);                  // the next frame abandons the rest
        settle();
        set_frame(0, 0);
        send_frame_rand(0, 0);
        settle();
    endtask

    // random frames, mostly well formed, some with noise and abandoned drains
    task automatic test_random_frames();
        int unsigned w, h, start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
                settle();
                case ($urandom_range(0, 9))
                    0:       w = 0;
                    1:       w = $urandom_range(11, 40);
                    default: w = $urandom_range(1, 10);
                endcase
                h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                set_frame(w, h);
            end
            if ($urandom_range(0, 9) == 0) send_flushes($urandom_range(1, 2));
            repeat (fit_width(reg_width) * fit_height(reg_height)) send_pixel_rand();
            if ($urandom_range(0, 6) == 0)
                send_flushes($urandom_range(0, fit_width(reg_width)));
            else
                send_flushes(fit_width(reg_width) + 1);
            frames_sent++;
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = sem_pkg::CFG_FRAME_WIDTH;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_cmd       = CMD_PIXEL;
        i_in_red    = '0;
        i_in_green  = '0;
        i_in_blue   = '0;
        mismatches  = 0;
        results_seen = 0;
        items_sent  = 0;
        frames_sent = 0;
        burst_left  = 0;
        col_pos = 0;
        row_pos = 0;
        owed_flushes = 0;
        reg_width  = 32'(sem_pkg::WIDTH_RESET);
        reg_height = 32'(sem_pkg::HEIGHT_RESET);
        cur_width  = 32'(sem_pkg::WIDTH_RESET);
        cur_height = 32'(sem_pkg::HEIGHT_RESET);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) win[i][j] = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_extremes();
        test_special_cases();
        test_mid_frame_config();
        test_size_limits();
        test_random_frames();

        if (expected_mags.size() != 0) begin
            mismatches++;
            $display("ERROR: %0d results never arrived", expected_mags.size());
        end
        $display("Covered %0d frames, %0d input transactions, %0d results, %0d errors",
                 frames_sent, items_sent, results_seen, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sobel_edge_magnitude_top.f =====
src/sem_pkg.sv
src/sem_ram.sv
src/sem_root.sv
src/sobel_edge_magnitude_top.sv
tb/tb_sobel_edge_magnitude_top.sv
